// ===== src/clm_pkg.sv =====
// Package for the cell limit debounce monitor.
// Field widths, register reset values, register indexes and stream packing.
// No dependencies.
`default_nettype none

package clm_pkg;

  // Number of monitored conditions that exist in the block
  localparam int SIG_COUNT        = 6;
  localparam int NUM_SIGNALS_DEF  = 6;

  // Field widths
  localparam int MV_W    = 13;
  localparam int TEMP_W  = 12;
  localparam int TICK_W  = 16;
  localparam int MASK_W  = 6;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_UV_LIMIT   = 3'd0,
    CFG_OV_LIMIT   = 3'd1,
    CFG_OT_LIMIT   = 3'd2,
    CFG_CHG_CAP    = 3'd3,
    CFG_DEBOUNCE   = 3'd4,
    CFG_EN_MASK    = 3'd5,
    CFG_BLANKING   = 3'd6
  } cfg_idx_t;

  // Register reset values
  localparam logic [MV_W-1:0]   UV_LIMIT_RST  = 13'd2700;
  localparam logic [MV_W-1:0]   OV_LIMIT_RST  = 13'd4170;
  localparam logic [TEMP_W-1:0] OT_LIMIT_RST  = 12'd550;
  localparam logic [TEMP_W-1:0] CHG_CAP_RST   = 12'd450;
  localparam logic [TICK_W-1:0] DEBOUNCE_RST  = 16'd1000;
  localparam logic [MASK_W-1:0] EN_MASK_RST   = 6'd39;
  localparam logic [TICK_W-1:0] BLANKING_RST  = 16'd1000;

  // Condition positions in flag vectors
  localparam int SIG_UV   = 0;
  localparam int SIG_OV   = 1;
  localparam int SIG_OT   = 2;
  localparam int SIG_COMM = 3;
  localparam int SIG_CELL = 4;
  localparam int SIG_THRM = 5;

  // Input item packing (highest bit first)
  typedef struct packed {
    logic [5:0]        pad;
    logic              charging;
    logic              therm_open_wire;
    logic              cell_open_wire;
    logic              comm_ok;
    logic [TEMP_W-1:0] max_temp_dc;
    logic [MV_W-1:0]   max_cell_mv;
    logic [MV_W-1:0]   min_cell_mv;
  } in_item_t;

  localparam int IN_TDATA_W  = $bits(in_item_t);
  localparam int OUT_TDATA_W = 8;

endpackage

`default_nettype wire

// ===== src/cell_limit_debounce_monitor.sv =====
// Cell limit debounce monitor: top level.
// Uses clm_pkg and clm_debounce.
//
// Usage
//   One input item per monitoring tick arrives on the s_ stream: cell
//   voltage extremes, maximum temperature, comm and open-wire status, and
//   the charging flag. One result item per input leaves on the m_ stream:
//   six debounced flags and their OR.
//   Configuration is a plain write port (cfg_we, cfg_addr, cfg_wdata);
//   write only while no item is in flight. Indexes beyond the register
//   list are ignored.
// Pipeline and throughput
//   The input register loads at the accept edge, the result register when
//   the item steps on, so each result passes through both registers.
//   One item per cycle sustained while m_tready stays high; the counters
//   update in the single stage between the two registers, so consecutive
//   items see each other's state.
// Reset
//   rst (synchronous) empties both registers, loads the register defaults,
//   and clears the blanking and debounce counters.
// Stall
//   While m_tready is low the result holds; the input register still takes
//   one more item, after which s_tready falls until the result drains.
`default_nettype none

module cell_limit_debounce_monitor
  import clm_pkg::*;
#(
  parameter int NUM_SIGNALS = NUM_SIGNALS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Input items
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [12:0] min_cell_mv, [25:13] max_cell_mv, [37:26] max_temp_dc,
  // [38] comm_ok, [39] cell_open_wire, [40] therm_open_wire, [41] charging
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // Result items
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [0] undervoltage_flag, [1] overvoltage_flag, [2] overtemp_flag,
  // [3] comm_error_flag, [4] cell_wire_flag, [5] therm_wire_flag,
  // [6] any_active
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  // Configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MV_W-1:0]   uv_limit;
  logic [MV_W-1:0]   ov_limit;
  logic [TEMP_W-1:0] ot_limit;
  logic [TEMP_W-1:0] chg_cap;
  logic [TICK_W-1:0] debounce_ticks;
  logic [MASK_W-1:0] en_mask;
  logic [TICK_W-1:0] blanking_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      uv_limit       <= UV_LIMIT_RST;
      ov_limit       <= OV_LIMIT_RST;
      ot_limit       <= OT_LIMIT_RST;
      chg_cap        <= CHG_CAP_RST;
      debounce_ticks <= DEBOUNCE_RST;
      en_mask        <= EN_MASK_RST;
      blanking_ticks <= BLANKING_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_UV_LIMIT: uv_limit       <= cfg_wdata[MV_W-1:0];
        CFG_OV_LIMIT: ov_limit       <= cfg_wdata[MV_W-1:0];
        CFG_OT_LIMIT: ot_limit       <= cfg_wdata[TEMP_W-1:0];
        CFG_CHG_CAP:  chg_cap        <= cfg_wdata[TEMP_W-1:0];
        CFG_DEBOUNCE: debounce_ticks <= cfg_wdata[TICK_W-1:0];
        CFG_EN_MASK:  en_mask        <= cfg_wdata[MASK_W-1:0];
        CFG_BLANKING: blanking_ticks <= cfg_wdata[TICK_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register, then result register
  // ---------------------------------------------------------------------
  logic     s1_valid;
  in_item_t s1_item;
  logic     out_adv;   // result register may load
  logic     in_acc;
  logic     step;      // item in input register is processed this cycle

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || out_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign step     = s1_valid && out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item <= in_item_t'(s_tdata);
    end
  end

  // ---------------------------------------------------------------------
  // Start-up blanking counter, saturates at blanking_ticks
  // ---------------------------------------------------------------------
  logic [TICK_W-1:0] blank_elapsed;
  logic              settled;

  assign settled = blank_elapsed >= blanking_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_elapsed <= '0;
    end else if (step) begin
      blank_elapsed <= settled ? blanking_ticks : blank_elapsed + TICK_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Conditions
  // ---------------------------------------------------------------------
  logic signed [TEMP_W-1:0] temp_lim;
  logic [SIG_COUNT-1:0]     cond;

  // While charging the lower of the two limits applies
  always_comb begin
    temp_lim = $signed(ot_limit);
    if (s1_item.charging && ($signed(chg_cap) < $signed(ot_limit))) begin
      temp_lim = $signed(chg_cap);
    end
  end

  always_comb begin
    cond           = '0;
    cond[SIG_UV]   = s1_item.min_cell_mv < uv_limit;
    cond[SIG_OV]   = s1_item.max_cell_mv > ov_limit;
    cond[SIG_OT]   = $signed(s1_item.max_temp_dc) > temp_lim;
    cond[SIG_COMM] = !s1_item.comm_ok;
    cond[SIG_CELL] = s1_item.cell_open_wire;
    cond[SIG_THRM] = s1_item.therm_open_wire;
  end

  // ---------------------------------------------------------------------
  // Debounce counters, one per signal; counters past the known six see a
  // condition that never holds
  // ---------------------------------------------------------------------
  logic [NUM_SIGNALS-1:0] cond_all;
  logic [NUM_SIGNALS-1:0] fired;
  logic [SIG_COUNT-1:0]   flag;
  logic                   any_active;

  for (genvar i = 0; i < NUM_SIGNALS; i++) begin : g_sig
    if (i < SIG_COUNT) begin : g_live
      assign cond_all[i] = cond[i];
    end else begin : g_spare
      assign cond_all[i] = 1'b0;
    end

    clm_debounce u_deb (
      .clk            (clk),
      .rst            (rst),
      .step           (step && settled),
      .cond           (cond_all[i]),
      .debounce_ticks (debounce_ticks),
      .fired          (fired[i])
    );
  end

  for (genvar j = 0; j < SIG_COUNT; j++) begin : g_flag
    if (j < NUM_SIGNALS) begin : g_has
      assign flag[j] = settled && en_mask[j] && fired[j];
    end else begin : g_none
      assign flag[j] = 1'b0;
    end
  end

  assign any_active = |flag;

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {1'b0, any_active, flag};
    end
  end

endmodule

`default_nettype wire

// ===== src/clm_debounce.sv =====
// Debounce counter for one monitored condition.
// Uses clm_pkg for the tick counter width.
`default_nettype none

module clm_debounce
  import clm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,      // one tick processed, blanking over
  input  wire logic              cond,
  input  wire logic [TICK_W-1:0] debounce_ticks,
  output logic                   fired
);

  logic [TICK_W-1:0] hold_count;
  logic              held;

  assign held  = hold_count >= debounce_ticks;
  assign fired = cond & held;

  // Saturates at the debounce time; a false tick clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
    end else if (step) begin
      if (!cond) begin
        hold_count <= '0;
      end else if (held) begin
        hold_count <= debounce_ticks;
      end else begin
        hold_count <= hold_count + TICK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/clm_checker.sv =====
// Port-level checks for the cell limit debounce monitor, bound to the top.
// Uses clm_pkg for stream widths.
`default_nettype none

module clm_checker
  import clm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata
);

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // An accepted item leads to a valid result on the output
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ##1 m_tvalid)
    else $error("accepted item produced no result");

  // Summary bit is the OR of the six flags
  a_any_or: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6] == (|m_tdata[5:0])))
    else $error("any_active does not match flags");

  // Padding bit stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7])
    else $error("result padding bit set");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind cell_limit_debounce_monitor clm_checker u_clm_checker (.*);

`default_nettype wire

// ===== tb/sv/cell_limit_debounce_monitor_tb.sv =====
// Self-checking testbench for cell_limit_debounce_monitor.
// Directed table then random phases, each item checked against the table's flags or a local flag predictor.
// Depends on clm_pkg and the cell_limit_debounce_monitor RTL.
`default_nettype none

module cell_limit_debounce_monitor_tb;
  import clm_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int FLAG_W = SIG_COUNT + 1;   // six flags plus any_active
  localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 3'd7;   // past the register list

  // Directed stimulus row: either one register write or one item
  typedef struct {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    in_item_t              item;
    bit                    typed;   // flags below are the expected result
    logic [FLAG_W-1:0]     flags;
  } dir_row_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  cell_limit_debounce_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #3_000_000;
    $display("cell_limit_debounce_monitor regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the register file and the tick state
  // ---------------------------------------------------------------------------
  logic        [MV_W-1:0]   uv_lim    = UV_LIMIT_RST;
  logic        [MV_W-1:0]   ov_lim    = OV_LIMIT_RST;
  logic signed [TEMP_W-1:0] ot_lim    = OT_LIMIT_RST;
  logic signed [TEMP_W-1:0] chg_cap   = CHG_CAP_RST;
  logic        [TICK_W-1:0] hold_need = DEBOUNCE_RST;
  logic        [MASK_W-1:0] en_mask   = EN_MASK_RST;
  logic        [TICK_W-1:0] blank_len = BLANKING_RST;

  logic [TICK_W-1:0] blank_count = '0;
  logic [TICK_W-1:0] hold_ticks [SIG_COUNT] = '{default: '0};

  // Expected results, oldest first
  logic [FLAG_W-1:0] flag_queue [$];

  int mismatch_count;
  int orphan_count;
  int items_sent;
  int results_seen;
  int fired_seen;
  int phase_count;
  bit tx_eager;   // sender skips its gaps
  bit rx_eager;   // receiver never stalls

  logic [OUT_TDATA_W-1:0] want_flags;
  string                  diff_names;
  string field_name [OUT_TDATA_W] = '{"undervoltage_flag", "overvoltage_flag",
    "overtemp_flag", "comm_error_flag", "cell_wire_flag", "therm_wire_flag",
    "any_active", "pad"};

  // One tick of the monitor: updates blanking and hold state, returns
  // {any_active, flags} for this item.
  function automatic logic [FLAG_W-1:0] predict_flags(in_item_t it);
    logic signed [TEMP_W-1:0] lim;
    logic [SIG_COUNT-1:0]     cond;
    logic [SIG_COUNT-1:0]     fired;
    logic                     settled;
    fired = '0;
    // charging pulls the limit down to the cap, never up
    lim = ot_lim;
    if (it.charging && chg_cap < ot_lim) lim = chg_cap;
    settled = (blank_count >= blank_len);
    if (!settled) blank_count = blank_count + 1'b1;
    else blank_count = blank_len;
    cond[SIG_UV]   = it.min_cell_mv < uv_lim;
    cond[SIG_OV]   = it.max_cell_mv > ov_lim;
    cond[SIG_OT]   = $signed(it.max_temp_dc) > lim;
    cond[SIG_COMM] = !it.comm_ok;
    cond[SIG_CELL] = it.cell_open_wire;
    cond[SIG_THRM] = it.therm_open_wire;
    // hold counters freeze while blanking
    if (settled) begin
      for (int i = 0; i < SIG_COUNT; i++) begin
        if (cond[i]) begin
          fired[i] = (hold_ticks[i] >= hold_need);
          if (hold_ticks[i] < hold_need) hold_ticks[i] = hold_ticks[i] + 1'b1;
          else hold_ticks[i] = hold_need;
        end else begin
          hold_ticks[i] = '0;
        end
      end
    end
    fired = fired & en_mask;   // disabled signals still count, never report
    return {|fired, fired};
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (flag_queue.size() == 0) begin
        orphan_count++;
        if (mismatch_count + orphan_count <= 10)
          $display("%0t: result %h with nothing expected", $realtime, m_tdata);
      end else begin
        want_flags = {1'b0, flag_queue.pop_front()};
        if (want_flags[SIG_COUNT]) fired_seen++;
        if (m_tdata !== want_flags) begin
          mismatch_count++;
          if (mismatch_count + orphan_count <= 10) begin
            diff_names = "";
            for (int i = 0; i < OUT_TDATA_W; i++)
              if (m_tdata[i] !== want_flags[i]) diff_names = {diff_names, " ", field_name[i]};
            $display("%0t: flags exp %b got %b, differ:%s", $realtime, want_flags,
                     m_tdata, diff_names);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = rx_eager ? 0 : $urandom_range(7);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Sends one item. tvalid is left high after the accept; the next call
  // either keeps it up (no gap) or drops it first, so it is never driven
  // twice in one step.
  task automatic send_tick(in_item_t it, bit typed, logic [FLAG_W-1:0] flags);
    int                gap;
    logic [FLAG_W-1:0] predicted;
    gap = tx_eager ? 0 : $urandom_range(7);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= it;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predicted = predict_flags(it);
    flag_queue.push_back(typed ? flags : predicted);
    items_sent++;
  endtask

  // Stop sending and let every expected result drain; the extra cycles
  // cover the two register stages.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (flag_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; our copy keeps only the register's own width.
  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      CFG_UV_LIMIT: uv_lim    = data[MV_W-1:0];
      CFG_OV_LIMIT: ov_lim    = data[MV_W-1:0];
      CFG_OT_LIMIT: ot_lim    = data[TEMP_W-1:0];
      CFG_CHG_CAP:  chg_cap   = data[TEMP_W-1:0];
      CFG_DEBOUNCE: hold_need = data[TICK_W-1:0];
      CFG_EN_MASK:  en_mask   = data[MASK_W-1:0];
      CFG_BLANKING: blank_len = data[TICK_W-1:0];
      default: ;   // unmapped index, ignored by the block
    endcase
  endtask

  function automatic dir_row_t tick_row(int mn, int mx, int t, bit ok, bit cow, bit tow,
                                        bit chg, bit typed, logic [FLAG_W-1:0] flags);
    dir_row_t r;
    r.is_cfg                 = 1'b0;
    r.addr                   = '0;
    r.wdata                  = '0;
    r.item                   = '0;
    r.item.min_cell_mv       = MV_W'(mn);
    r.item.max_cell_mv       = MV_W'(mx);
    r.item.max_temp_dc       = TEMP_W'(t);
    r.item.comm_ok           = ok;
    r.item.cell_open_wire    = cow;
    r.item.therm_open_wire   = tow;
    r.item.charging          = chg;
    r.typed                  = typed;
    r.flags                  = flags;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_ADDR_W-1:0] a, int d);
    dir_row_t r;
    r        = tick_row(0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0);
    r.is_cfg = 1'b1;
    r.addr   = a;
    r.wdata  = CFG_DATA_W'(d);
    return r;
  endfunction

  // Random value in [lo, hi], leaning toward both ends
  function automatic int pick_between(int lo, int hi);
    int span;
    span = hi - lo;
    case ($urandom_range(3))
      0:       return lo + $urandom_range(span < 3 ? span : 3);
      1:       return hi - $urandom_range(span < 3 ? span : 3);
      default: return lo + $urandom_range(span);
    endcase
  endfunction

  // Sticky plan of which conditions hold: bits follow the flag order,
  // bit 6 is the charging state. Flips are rare so runs last long enough
  // to get through the debounce, but short broken runs happen too.
  logic [SIG_COUNT:0] cond_plan = '0;

  function automatic in_item_t plan_tick();
    in_item_t                 it;
    logic [63:0]              r;
    logic signed [TEMP_W-1:0] lim;
    int                       tl;
    for (int i = 0; i <= SIG_COUNT; i++)
      if ($urandom_range(5) == 0) cond_plan[i] = ~cond_plan[i];
    // some pure noise: every input bit at random
    if ($urandom_range(9) == 0) begin
      r      = {$urandom, $urandom};
      it     = r[IN_TDATA_W-1:0];
      it.pad = '0;
      return it;
    end
    it                 = '0;
    it.charging        = cond_plan[SIG_COUNT];
    it.comm_ok         = !cond_plan[SIG_COMM];
    it.cell_open_wire  = cond_plan[SIG_CELL];
    it.therm_open_wire = cond_plan[SIG_THRM];
    if (cond_plan[SIG_UV] && uv_lim != 0)
      it.min_cell_mv = MV_W'(pick_between(0, int'(uv_lim) - 1));
    else
      it.min_cell_mv = MV_W'(pick_between(int'(uv_lim), 8191));
    if (cond_plan[SIG_OV] && ov_lim != 8191)
      it.max_cell_mv = MV_W'(pick_between(int'(ov_lim) + 1, 8191));
    else
      it.max_cell_mv = MV_W'(pick_between(0, int'(ov_lim)));
    lim = ot_lim;
    if (it.charging && chg_cap < ot_lim) lim = chg_cap;
    tl = int'(lim);
    if (cond_plan[SIG_OT] && tl != 2047)
      it.max_temp_dc = TEMP_W'(pick_between(tl + 1, 2047));
    else
      it.max_temp_dc = TEMP_W'(pick_between(-2048, tl));
    return it;
  endfunction

  // Per-phase register choice; phase 0 pins the opposite extremes to the
  // directed part, later phases mostly use small debounce and blanking.
  task automatic config_phase(int phase);
    int deb;
    int blank;
    int uv;
    int ov;
    int ot;
    int cap;
    int mask;
    if (phase == 0) begin
      uv = 0; ov = 0; ot = 2047; cap = -2048; deb = 65535; mask = 0; blank = 65535;
    end else begin
      case ($urandom_range(5))
        0:       uv = 0;
        1:       uv = 8191;
        2:       uv = int'($urandom_range(16'hFFFF));   // upper bits dropped
        3:       uv = 5000;
        default: uv = $urandom_range(3300, 2500);
      endcase
      case ($urandom_range(5))
        0:       ov = 0;
        1:       ov = 8191;
        2:       ov = int'($urandom_range(16'hFFFF));
        3:       ov = 5000;
        default: ov = $urandom_range(4300, 3900);
      endcase
      case ($urandom_range(6))
        0:       ot = -400;
        1:       ot = 1500;
        2:       ot = int'($urandom_range(16'hFFFF));
        3:       ot = -2048;
        default: ot = int'($urandom_range(800)) - 100;
      endcase
      case ($urandom_range(6))
        0:       cap = -400;
        1:       cap = 1500;
        2:       cap = int'($urandom_range(16'hFFFF));
        3:       cap = 2047;
        default: cap = int'($urandom_range(800)) - 100;
      endcase
      case ($urandom_range(9))
        0:       deb = 65535;
        1:       deb = $urandom_range(40, 7);
        default: deb = $urandom_range(6);
      endcase
      case ($urandom_range(7))
        0:       mask = 0;
        1:       mask = 63;
        default: mask = int'($urandom_range(16'hFFFF));
      endcase
      case ($urandom_range(11))
        0:       blank = 65535;
        1:       blank = $urandom_range(30, 5);
        default: blank = $urandom_range(4);
      endcase
    end
    cfg_write(CFG_UV_LIMIT, CFG_DATA_W'(uv));
    cfg_write(CFG_OV_LIMIT, CFG_DATA_W'(ov));
    cfg_write(CFG_OT_LIMIT, CFG_DATA_W'(ot));
    cfg_write(CFG_CHG_CAP,  CFG_DATA_W'(cap));
    cfg_write(CFG_DEBOUNCE, CFG_DATA_W'(deb));
    cfg_write(CFG_EN_MASK,  CFG_DATA_W'(mask));
    cfg_write(CFG_BLANKING, CFG_DATA_W'(blank));
    if ($urandom_range(7) == 0) cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_tab [$];
    int       random_sent;
    int       phase_len;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    tx_eager  = 1'b0;
    rx_eager  = 1'b0;

    // Reset defaults still in place: start-up blanking hides even the
    // field extremes with every condition true
    dir_tab.push_back(tick_row(0, 8191, 2047, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 7'h00));
    dir_tab.push_back(tick_row(8191, 0, -2048, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'h00));
    // No blanking, no debounce, all signals on: conditions map straight to flags
    dir_tab.push_back(cfg_row(CFG_BLANKING, 0));
    dir_tab.push_back(cfg_row(CFG_DEBOUNCE, 0));
    dir_tab.push_back(cfg_row(CFG_EN_MASK, 63));
    dir_tab.push_back(tick_row(0, 8191, 2047, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F));
    dir_tab.push_back(tick_row(8191, 0, -2048, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'h00));
    // limits themselves do not trip
    dir_tab.push_back(tick_row(2700, 4170, 550, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'h00));
    dir_tab.push_back(tick_row(2699, 4171, 551, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 7'h47));
    // charging cap 45.0 degC below the 55.0 degC limit
    dir_tab.push_back(tick_row(3500, 3600, 451, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 7'h44));
    dir_tab.push_back(tick_row(3500, 3600, 450, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 7'h00));
    dir_tab.push_back(tick_row(3500, 3600, 250, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'h48));
    dir_tab.push_back(tick_row(3500, 3600, 250, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 7'h50));
    dir_tab.push_back(tick_row(3500, 3600, 250, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 7'h60));
    // Debounce of two; UV counts but is masked off, comm fires on the third tick
    dir_tab.push_back(cfg_row(CFG_DEBOUNCE, 2));
    dir_tab.push_back(cfg_row(CFG_EN_MASK, 6'h2A));
    repeat (3) dir_tab.push_back(tick_row(2000, 3600, 250, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    dir_tab.push_back(cfg_row(CFG_UNMAPPED, 16'hFFFF));
    // Shortened debounce: hold OV four ticks at five, then drop to one
    dir_tab.push_back(cfg_row(CFG_DEBOUNCE, 5));
    repeat (4) dir_tab.push_back(tick_row(3500, 5000, 250, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    dir_tab.push_back(cfg_row(CFG_DEBOUNCE, 1));
    dir_tab.push_back(tick_row(3500, 5000, 250, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, '0));
    // Out-of-range limits used raw, and blanking restarted mid-run
    dir_tab.push_back(cfg_row(CFG_UV_LIMIT, 8191));
    dir_tab.push_back(cfg_row(CFG_OV_LIMIT, 8191));
    dir_tab.push_back(cfg_row(CFG_OT_LIMIT, 12'h800));
    dir_tab.push_back(cfg_row(CFG_CHG_CAP, 12'h7FF));
    dir_tab.push_back(cfg_row(CFG_EN_MASK, 63));
    dir_tab.push_back(cfg_row(CFG_DEBOUNCE, 0));
    dir_tab.push_back(cfg_row(CFG_BLANKING, 3));
    repeat (3) dir_tab.push_back(tick_row(8190, 8191, -2047, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                          7'h00));
    dir_tab.push_back(tick_row(8190, 8191, -2047, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        cfg_write(dir_tab[i].addr, dir_tab[i].wdata);
      end else begin
        send_tick(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].flags);
      end
    end

    // Random phases: drain, reprogram every register, then a burst of ticks.
    // The drain before each phase is also the full pause of the sender.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_drained();
      config_phase(phase_count);
      tx_eager  = ($urandom_range(3) == 0);
      rx_eager  = ($urandom_range(3) == 0);
      phase_len = $urandom_range(70, 20);
      for (int k = 0; k < phase_len; k++) send_tick(plan_tick(), 1'b0, '0);
      random_sent += phase_len;
      phase_count++;
    end

    s_tvalid <= 1'b0;
    while (flag_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d items, %0d results, %0d with a fault reported, %0d random phases",
             items_sent, results_seen, fired_seen, phase_count);
    $display("%0d mismatches, %0d unexpected results", mismatch_count, orphan_count);
    if (mismatch_count == 0 && orphan_count == 0 && flag_queue.size() == 0) begin
      $display("cell_limit_debounce_monitor regression: pass");
    end else begin
      $display("cell_limit_debounce_monitor regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
